// ===== rtl/a64bsd_pkg.sv =====
// shared types and constants for the arm64 branch and system decoder
package a64bsd_pkg;

   localparam int INSTR_W  = 32;
   localparam int MNEM_W   = 5;
   localparam int CLASS_W  = 4;
   localparam int COND_W   = 4;
   localparam int REG_W    = 5;
   localparam int OFFSET_W = 28;
   localparam int BIT_W    = 6;

   localparam logic [INSTR_W-1:0] UNCOND_MASK  = 32'h7C00_0000;
   localparam logic [INSTR_W-1:0] UNCOND_VALUE = 32'h1400_0000;
   localparam logic [INSTR_W-1:0] CMPBR_MASK   = 32'h7E00_0000;
   localparam logic [INSTR_W-1:0] CMPBR_VALUE  = 32'h3400_0000;
   localparam logic [INSTR_W-1:0] TSTBR_VALUE  = 32'h3600_0000;
   localparam logic [INSTR_W-1:0] CONDBR_MASK  = 32'hFF00_0010;
   localparam logic [INSTR_W-1:0] CONDBR_VALUE = 32'h5400_0000;
   localparam logic [INSTR_W-1:0] REGBR_MASK   = 32'hFE00_0000;
   localparam logic [INSTR_W-1:0] REGBR_VALUE  = 32'hD600_0000;
   localparam logic [INSTR_W-1:0] SYS_MASK     = 32'hFFC0_0000;
   localparam logic [INSTR_W-1:0] SYS_VALUE    = 32'hD500_0000;

   localparam logic [MNEM_W-1:0] MN_B     = 5'd0;
   localparam logic [MNEM_W-1:0] MN_BL    = 5'd1;
   localparam logic [MNEM_W-1:0] MN_BCOND = 5'd2;
   localparam logic [MNEM_W-1:0] MN_CBZ   = 5'd3;
   localparam logic [MNEM_W-1:0] MN_CBNZ  = 5'd4;
   localparam logic [MNEM_W-1:0] MN_TBZ   = 5'd5;
   localparam logic [MNEM_W-1:0] MN_TBNZ  = 5'd6;
   localparam logic [MNEM_W-1:0] MN_BR    = 5'd7;
   localparam logic [MNEM_W-1:0] MN_BLR   = 5'd8;
   localparam logic [MNEM_W-1:0] MN_RET   = 5'd9;
   localparam logic [MNEM_W-1:0] MN_ERET  = 5'd10;
   localparam logic [MNEM_W-1:0] MN_DRPS  = 5'd11;
   localparam logic [MNEM_W-1:0] MN_NOP   = 5'd12;
   localparam logic [MNEM_W-1:0] MN_MRS   = 5'd18;

   localparam logic [CLASS_W-1:0] CL_BRANCH = 4'd0;
   localparam logic [CLASS_W-1:0] CL_LINK   = 4'd1;
   localparam logic [CLASS_W-1:0] CL_CBZ    = 4'd2;
   localparam logic [CLASS_W-1:0] CL_CBNZ   = 4'd3;
   localparam logic [CLASS_W-1:0] CL_TBZ    = 4'd4;
   localparam logic [CLASS_W-1:0] CL_TBNZ   = 4'd5;
   localparam logic [CLASS_W-1:0] CL_BR     = 4'd6;
   localparam logic [CLASS_W-1:0] CL_BLR    = 4'd7;
   localparam logic [CLASS_W-1:0] CL_RETURN = 4'd8;
   localparam logic [CLASS_W-1:0] CL_HINT   = 4'd9;
   localparam logic [CLASS_W-1:0] CL_MRS    = 4'd10;

   localparam logic [3:0] OPC_BR   = 4'd0;
   localparam logic [3:0] OPC_BLR  = 4'd1;
   localparam logic [3:0] OPC_RET  = 4'd2;
   localparam logic [3:0] OPC_ERET = 4'd4;
   localparam logic [3:0] OPC_DRPS = 4'd5;

   localparam logic [REG_W-1:0] REG_ZR = 5'd31;

   typedef struct packed {
      logic                       valid_res;
      logic [MNEM_W-1:0]          mnemonic;
      logic [CLASS_W-1:0]         inst_class;
      logic [COND_W-1:0]          cond_code;
      logic [REG_W-1:0]           dest_reg;
      logic                       dest_is_x;
      logic [REG_W-1:0]           target_reg;
      logic signed [OFFSET_W-1:0] offset;
      logic                       has_offset;
      logic [BIT_W-1:0]           test_bit;
      logic                       wide;
   } result_type;

endpackage

// ===== rtl/arm64_branch_system_decoder.sv =====
// arm64 branch and system instruction decoder, top level
// the response is registered and shown in the cycle after a request is accepted
// throughput: one transaction per cycle while the held response is not stalled; there is a single result register
// a new request is taken while the held response is being taken in the same cycle
// reset: synchronous, active high, clears the response valid; no other state
module arm64_branch_system_decoder (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_stall,
   input  logic [a64bsd_pkg::INSTR_W-1:0]               req_instruction,
   output logic                                         rsp_valid,
   input  logic                                         rsp_stall,
   output logic                                         rsp_valid_res,
   output logic [a64bsd_pkg::MNEM_W-1:0]                rsp_mnemonic,
   output logic [a64bsd_pkg::CLASS_W-1:0]               rsp_inst_class,
   output logic [a64bsd_pkg::COND_W-1:0]                rsp_cond_code,
   output logic [a64bsd_pkg::REG_W-1:0]                 rsp_dest_reg,
   output logic                                         rsp_dest_is_x,
   output logic [a64bsd_pkg::REG_W-1:0]                 rsp_target_reg,
   output logic signed [a64bsd_pkg::OFFSET_W-1:0]       rsp_offset,
   output logic                                         rsp_has_offset,
   output logic [a64bsd_pkg::BIT_W-1:0]                 rsp_test_bit,
   output logic                                         rsp_wide
);
   import a64bsd_pkg::*;

   logic [INSTR_W-1:0] w;
   logic               top;
   logic               op24;
   logic [REG_W-1:0]   rt;
   logic [REG_W-1:0]   rn;
   logic [3:0]         opc;
   logic               regbr_ok;
   logic               hint_ok;
   logic [OFFSET_W-1:0] off19;
   result_type         res_in;
   result_type         res_ff;
   logic               valid_in;
   logic               valid_ff;
   logic               accept;

   assign w    = req_instruction;
   assign top  = w[31];
   assign op24 = w[24];
   assign rt   = w[4:0];
   assign rn   = w[9:5];
   assign opc  = w[24:21];
   assign off19 = {{7{w[23]}}, w[23:5], 2'b00};
   assign regbr_ok = (w[20:16] == REG_ZR) && (rt == '0) && (w[15:10] == '0);
   assign hint_ok  = (w[20:19] == 2'd0) && (w[18:16] == 3'd3) && (w[15:12] == 4'd2)
                     && (rt == REG_ZR) && (w[11:8] == 4'd0) && (w[7:5] < 3'd6);

   always_comb begin
      res_in = '0;
      if ((w & UNCOND_MASK) == UNCOND_VALUE) begin
         res_in.valid_res  = 1'b1;
         res_in.mnemonic   = top ? MN_BL : MN_B;
         res_in.inst_class = top ? CL_LINK : CL_BRANCH;
         res_in.offset     = {w[25:0], 2'b00};
         res_in.has_offset = 1'b1;
      end else if ((w & CMPBR_MASK) == CMPBR_VALUE) begin
         res_in.valid_res  = 1'b1;
         res_in.mnemonic   = op24 ? MN_CBNZ : MN_CBZ;
         res_in.inst_class = op24 ? CL_CBNZ : CL_CBZ;
         res_in.dest_reg   = rt;
         res_in.dest_is_x  = top;
         res_in.offset     = off19;
         res_in.has_offset = 1'b1;
         res_in.wide       = top;
      end else if ((w & CMPBR_MASK) == TSTBR_VALUE) begin
         res_in.valid_res  = 1'b1;
         res_in.mnemonic   = op24 ? MN_TBNZ : MN_TBZ;
         res_in.inst_class = op24 ? CL_TBNZ : CL_TBZ;
         res_in.dest_reg   = rt;
         res_in.dest_is_x  = top;
         res_in.offset     = {{12{w[18]}}, w[18:5], 2'b00};
         res_in.has_offset = 1'b1;
         res_in.test_bit   = {top, w[23:19]};
         res_in.wide       = top;
      end else if ((w & CONDBR_MASK) == CONDBR_VALUE) begin
         res_in.valid_res  = 1'b1;
         res_in.mnemonic   = MN_BCOND;
         res_in.inst_class = CL_BRANCH;
         res_in.cond_code  = w[3:0];
         res_in.offset     = off19;
         res_in.has_offset = 1'b1;
      end else if ((w & REGBR_MASK) == REGBR_VALUE) begin
         res_in.target_reg = rn;
         res_in.wide       = 1'b1;
         unique case (opc)
            OPC_BR: begin
               res_in.valid_res  = regbr_ok;
               res_in.mnemonic   = MN_BR;
               res_in.inst_class = CL_BR;
            end
            OPC_BLR: begin
               res_in.valid_res  = regbr_ok;
               res_in.mnemonic   = MN_BLR;
               res_in.inst_class = CL_BLR;
            end
            OPC_RET: begin
               res_in.valid_res  = regbr_ok;
               res_in.mnemonic   = MN_RET;
               res_in.inst_class = CL_RETURN;
            end
            OPC_ERET: begin
               res_in.valid_res  = regbr_ok && (rn == REG_ZR);
               res_in.mnemonic   = MN_ERET;
               res_in.inst_class = CL_RETURN;
            end
            OPC_DRPS: begin
               res_in.valid_res  = regbr_ok && (rn == REG_ZR);
               res_in.mnemonic   = MN_DRPS;
               res_in.inst_class = CL_RETURN;
            end
            default: begin
               res_in.valid_res = 1'b0;
            end
         endcase
         if (!res_in.valid_res) begin
            res_in = '0;
         end
      end else if ((w & SYS_MASK) == SYS_VALUE) begin
         if (hint_ok) begin
            res_in.valid_res  = 1'b1;
            res_in.mnemonic   = MN_NOP + {2'b00, w[7:5]};
            res_in.inst_class = CL_HINT;
         end else if (w[21] && (rt != REG_ZR)) begin
            res_in.valid_res  = 1'b1;
            res_in.mnemonic   = MN_MRS;
            res_in.inst_class = CL_MRS;
            res_in.dest_reg   = rt;
            res_in.dest_is_x  = 1'b1;
            res_in.wide       = 1'b1;
         end
      end
   end

   assign req_stall = valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_valid_res  = res_ff.valid_res;
   assign rsp_mnemonic   = res_ff.mnemonic;
   assign rsp_inst_class = res_ff.inst_class;
   assign rsp_cond_code  = res_ff.cond_code;
   assign rsp_dest_reg   = res_ff.dest_reg;
   assign rsp_dest_is_x  = res_ff.dest_is_x;
   assign rsp_target_reg = res_ff.target_reg;
   assign rsp_offset     = res_ff.offset;
   assign rsp_has_offset = res_ff.has_offset;
   assign rsp_test_bit   = res_ff.test_bit;
   assign rsp_wide       = res_ff.wide;

endmodule

// ===== rtl/a64bsd_check.sv =====
// port-level assertions for the decoder and their bind
module a64bsd_check (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_stall,
   input logic                                   rsp_valid,
   input logic                                   rsp_stall,
   input logic                                   rsp_valid_res,
   input logic [a64bsd_pkg::MNEM_W-1:0]          rsp_mnemonic,
   input logic [a64bsd_pkg::CLASS_W-1:0]         rsp_inst_class,
   input logic [a64bsd_pkg::COND_W-1:0]          rsp_cond_code,
   input logic [a64bsd_pkg::REG_W-1:0]           rsp_dest_reg,
   input logic                                   rsp_dest_is_x,
   input logic [a64bsd_pkg::REG_W-1:0]           rsp_target_reg,
   input logic signed [a64bsd_pkg::OFFSET_W-1:0] rsp_offset,
   input logic                                   rsp_has_offset,
   input logic [a64bsd_pkg::BIT_W-1:0]           rsp_test_bit,
   input logic                                   rsp_wide
);
   import a64bsd_pkg::*;

   // held response stays put while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_mnemonic) && $stable(rsp_offset))
      else $error("stalled response changed");

   // accepted request shows up as a response in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted transaction did not produce a response");

   // rejected words carry all-zero fields
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_mnemonic == '0 && rsp_inst_class == '0
         && rsp_cond_code == '0 && rsp_dest_reg == '0 && !rsp_dest_is_x
         && rsp_target_reg == '0 && rsp_offset == '0 && !rsp_has_offset
         && rsp_test_bit == '0 && !rsp_wide)
      else $error("invalid response has non-zero fields");

   // test bit width agrees with the wide flag
   a_tbz_wide: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res && (rsp_mnemonic == MN_TBZ || rsp_mnemonic == MN_TBNZ)
         |-> rsp_wide == rsp_test_bit[BIT_W-1] && rsp_dest_is_x == rsp_wide)
      else $error("test bit and width disagree");

   // immediate branches never name a target register
   a_offset_no_rn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_has_offset |-> rsp_target_reg == '0)
      else $error("offset branch with target register");

endmodule

bind arm64_branch_system_decoder a64bsd_check u_a64bsd_check (.*);
